// File: rtl/lrfu_pkg.sv
// lrfu_pkg: shared constants, types and the decay table for the lrfu replacement block
// no dependencies
package lrfu_pkg;

    localparam int ENTRIES     = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int OCC_W       = $clog2(ENTRIES + 1);
    localparam int TBL_BITS    = 8;
    localparam int LAMBDA_W    = 17;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 17'd32768;
    localparam logic [31:0] ONE_Q16 = 32'd65536;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch the input item, reset the scan
        logic scan_rd;    // read the scan entry, form its decay exponent
        logic scan_mul;   // multiply the entry weight by its decay factor
        logic scan_eval;  // finish decay of the entry read last
        logic scan_adv;   // step the scan index
        logic do_read;    // update the hit entry
        logic do_append;  // append at the occupancy index
        logic evict_rd;   // start the gap closing
        logic shift_step; // move one entry down
        logic do_clear;   // one clearing step
        logic finish;     // load the output register
    } lrfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       scan_last;
        logic       match;
        logic       shift_last;
    } lrfu_stat_t;

    // decay factor for 2^-(f/2^TBL_BITS) in Q1.16
    function automatic logic [16:0] decay_rom(input logic [TBL_BITS-1:0] f);
        logic [63:0] acc;
        logic [31:0] root [10];
        root[0] = 32'd3037000500; root[1] = 32'd3611622603;
        root[2] = 32'd3938502376; root[3] = 32'd4112874773;
        root[4] = 32'd4202935002; root[5] = 32'd4248701965;
        root[6] = 32'd4271771997; root[7] = 32'd4283353945;
        root[8] = 32'd4289156690; root[9] = 32'd4292061010;
        acc = 64'd1 << 32;
        for (int k = 0; k < TBL_BITS; k++) begin
            if (f[k] && (TBL_BITS - k) >= 1 && (TBL_BITS - k) <= 10) begin
                acc = (acc * {32'd0, root[TBL_BITS-k-1]} + (64'd1 << 31)) >> 32;
            end
        end
        acc = (acc + 64'h8000) >> 16;
        return acc[16:0];
    endfunction

endpackage

// File: rtl/lrfu_ctrl.sv
// lrfu_ctrl: sequencing state machine of the lrfu replacement block
// depends on lrfu_pkg
module lrfu_ctrl
    import lrfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_busy,
    output lrfu_cmd_t  cmd,
    input  lrfu_stat_t stat
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_SRD   = 10'b0000000100,
        S_SMUL  = 10'b0000001000,
        S_SEVAL = 10'b0000010000,
        S_HIT   = 10'b0000100000,
        S_EVRD  = 10'b0001000000,
        S_SHIFT = 10'b0010000000,
        S_APP   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.cmd)
                    CMD_WRITE:
                        state_next = stat.full ? S_SRD : S_APP;
                    default:
                        state_next = S_SRD;
                endcase
            end
            S_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.scan_mul = 1'b1;
                state_next = S_SEVAL;
            end
            S_SEVAL:
            begin
                cmd.scan_eval = 1'b1;
                if (stat.cmd != CMD_WRITE && stat.cmd != CMD_CLEAR && stat.match)
                    state_next = (stat.cmd == CMD_READ) ? S_HIT : S_DONE;
                else if (stat.scan_last)
                    state_next = (stat.cmd == CMD_WRITE) ? S_EVRD : S_DONE;
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next = S_SRD;
                end
                if (stat.cmd == CMD_CLEAR)
                    cmd.do_clear = 1'b1;
            end
            S_HIT:
            begin
                cmd.do_read = 1'b1;
                state_next = S_DONE;
            end
            S_EVRD:
            begin
                cmd.evict_rd = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last)
                    state_next = S_APP;
            end
            S_APP:
            begin
                cmd.do_append = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.finish) else $error("finish while idle");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == S_DISP) else $error("start did not dispatch");

endmodule

// File: rtl/lrfu_dp.sv
// lrfu_dp: slot tables, scan, decay and compaction datapath
// depends on lrfu_pkg
module lrfu_dp
    import lrfu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [LAMBDA_W-1:0] lambda,
    input  logic [33:0]         in_data,
    input  lrfu_cmd_t           cmd,
    output lrfu_stat_t          stat,
    output logic [33:0]         res
);

    logic [15:0] file_mem [ENTRIES];
    logic [15:0] seg_mem  [ENTRIES];
    logic [31:0] wt_mem   [ENTRIES];
    logic [31:0] tm_mem   [ENTRIES];

    logic [16:0] decay_tbl [2**TBL_BITS];

    logic [1:0]       op_reg;
    logic [15:0]      fid_reg, sid_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [31:0]      now_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] best_reg;
    logic [31:0]      best_w_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_w_reg;
    logic [15:0]      rd_file_reg, rd_seg_reg;
    logic [31:0]      rd_w_reg;
    logic [48:0]      p_reg;
    logic [48:0]      prod_reg;
    logic [5:0]       ip_reg;
    logic             ipbig_reg;
    logic [31:0]      w_next;
    logic             match_c;
    logic [IDX_W-1:0] sh_reg;
    logic             ev_reg;
    logic [15:0]      ev_fid_reg, ev_sid_reg;

    logic [32:0] wsum_c;
    logic        ent_ok;
    logic [IDX_W-1:0] last_idx;

    assign last_idx = IDX_W'(ENTRIES - 1);
    assign ent_ok = ({1'b0, idx_reg} < occ_reg);

    // constant decay table
    for (genvar g = 0; g < 2**TBL_BITS; g++)
    begin : g_decay
        assign decay_tbl[g] = decay_rom(TBL_BITS'(g));
    end

    // decay final step: shift the registered product
    always_comb
    begin
        if (ipbig_reg)
            w_next = '0;
        else
            w_next = 32'(prod_reg >> (16 + ip_reg));
    end

    assign match_c = ent_ok && rd_file_reg == fid_reg && rd_seg_reg == sid_reg;
    assign wsum_c  = {1'b0, hit_w_reg} + {1'b0, ONE_Q16};

    assign stat.cmd        = op_reg;
    assign stat.full       = (occ_reg >= OCC_W'(ENTRIES));
    assign stat.scan_last  = (idx_reg == last_idx) || (op_reg != CMD_WRITE && op_reg != CMD_CLEAR
                             && {1'b0, idx_reg} + 1'b1 >= occ_reg);
    assign stat.match      = match_c;
    assign stat.shift_last = (sh_reg == last_idx);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            now_reg <= '0;
        end
        else
        begin
            if (cmd.do_read)
                now_reg <= now_reg + 32'd1;
            if (cmd.evict_rd)
            begin
                now_reg <= now_reg + 32'd1;
                occ_reg <= OCC_W'(ENTRIES - 1);
            end
            if (cmd.do_append)
                occ_reg <= occ_reg + 1'b1;
        end
    end

    // scan and per-item registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= in_data[1:0];
            fid_reg <= in_data[17:2];
            sid_reg <= in_data[33:18];
            idx_reg <= '0;
            hit_reg <= 1'b0;
            ev_reg  <= 1'b0;
            best_w_reg <= '1;
            best_reg   <= '0;
        end
        // entry read and decay exponent
        if (cmd.scan_rd)
        begin
            rd_file_reg <= file_mem[idx_reg];
            rd_seg_reg  <= seg_mem[idx_reg];
            rd_w_reg    <= wt_mem[idx_reg];
            p_reg       <= 32'(now_reg - tm_mem[idx_reg]) * lambda;
        end
        // weight times decay factor
        if (cmd.scan_mul)
        begin
            ipbig_reg <= (p_reg[48:16] >= 33'd32);
            ip_reg    <= p_reg[21:16];
            prod_reg  <= rd_w_reg * decay_tbl[p_reg[15:16-TBL_BITS]];
        end
        if (cmd.scan_eval)
        begin
            if (match_c && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
                hit_w_reg   <= w_next;
            end
            if (idx_reg == '0 || w_next < best_w_reg)
            begin
                best_w_reg <= w_next;
                best_reg   <= idx_reg;
            end
        end
        if (cmd.scan_adv)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.evict_rd)
        begin
            ev_reg     <= 1'b1;
            ev_fid_reg <= file_mem[best_reg];
            ev_sid_reg <= seg_mem[best_reg];
            sh_reg     <= best_reg;
        end
        if (cmd.shift_step && sh_reg != last_idx)
            sh_reg <= sh_reg + 1'b1;
    end

    // slot tables, one write port each
    always_ff @(posedge clk)
    begin
        if (cmd.do_clear)
            wt_mem[idx_reg] <= '0;
        else if (cmd.do_read)
        begin
            wt_mem[hit_idx_reg] <= wsum_c[32] ? '1 : wsum_c[31:0];
            tm_mem[hit_idx_reg] <= now_reg;
        end
        else if (cmd.shift_step && sh_reg != last_idx)
        begin
            file_mem[sh_reg] <= file_mem[sh_reg + 1'b1];
            seg_mem[sh_reg]  <= seg_mem[sh_reg + 1'b1];
            wt_mem[sh_reg]   <= wt_mem[sh_reg + 1'b1];
            tm_mem[sh_reg]   <= tm_mem[sh_reg + 1'b1];
        end
        else if (cmd.do_append)
        begin
            file_mem[occ_reg[IDX_W-1:0]] <= fid_reg;
            seg_mem[occ_reg[IDX_W-1:0]]  <= sid_reg;
            wt_mem[occ_reg[IDX_W-1:0]]   <= ONE_Q16;
            tm_mem[occ_reg[IDX_W-1:0]]   <= now_reg;
        end
    end

    // result fields: found, evicted, evict file, evict segment
    assign res = {ev_reg ? ev_sid_reg : 16'd0, ev_reg ? ev_fid_reg : 16'd0, ev_reg,
                  hit_reg && (op_reg == CMD_READ || op_reg == CMD_LOOKUP)};

    a_occ: assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy overflow");
    a_app: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_append |-> occ_reg < OCC_W'(ENTRIES)) else $error("append into full table");
    a_ev: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict_rd |-> stat.full) else $error("evict while not full");

endmodule

// File: rtl/lrfu_block_replacement.sv
// lrfu_block_replacement: top level of the lrfu replacement table, uses lrfu_pkg, lrfu_ctrl, lrfu_dp
// a write to a free slot appends without a scan; read and lookup scan until a hit or up to the last
// occupied slot; clear walks every slot; a full write scans every slot, evicts, compacts and appends
// each scanned slot is read, decay multiplied and compared; compaction moves a slot a cycle
// one item in flight; the next is taken after its result is registered, and a result left waiting
// in the output register holds the block; rst_n clears occupancy and clock and sets lambda to 0.5
module lrfu_block_replacement
    import lrfu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LAMBDA_W-1:0] cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,  // cmd, file_id, seg_id
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata   // found, evicted, evict_file_id, evict_seg_id
);

    logic [LAMBDA_W-1:0] lambda_reg;
    logic                ovalid_reg;
    logic [33:0]         odata_reg;
    logic [33:0]         res;
    lrfu_cmd_t           cmd;
    lrfu_stat_t          stat;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {6'd0, odata_reg};

    // lambda register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lambda_reg <= LAMBDA_RESET;
        else if (cfg_valid)
            lambda_reg <= cfg_data;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.finish)
            ovalid_reg <= 1'b1;
        else if (m_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            odata_reg <= res;
    end

    lrfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_busy (ovalid_reg && !m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lrfu_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .lambda  (lambda_reg),
        .in_data (s_tdata[33:0]),
        .cmd     (cmd),
        .stat    (stat),
        .res     (res)
    );

endmodule

// File: tb/tb_lrfu_block_replacement.sv
// tb_lrfu_block_replacement: self-checking testbench for the lrfu replacement table
// depends on lrfu_pkg and lrfu_block_replacement; keeps its own model of table state
module tb_lrfu_block_replacement;
    import lrfu_pkg::*;

    // packed from the lowest bit up: found, evicted, evict file, evict segment
    typedef struct packed {
        logic [15:0] evict_seg;
        logic [15:0] evict_file;
        logic        evicted;
        logic        found;
    } table_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LAMBDA_W-1:0] cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;   // cmd, file_id, seg_id
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;   // found, evicted, evict_file_id, evict_seg_id

    // table model
    logic [15:0]   mdl_file [ENTRIES];
    logic [15:0]   mdl_seg [ENTRIES];
    logic [31:0]   mdl_weight [ENTRIES];
    logic [31:0]   mdl_hit [ENTRIES];
    int            mdl_occ;
    logic [31:0]   mdl_clock;
    logic [16:0]   mdl_lambda;

    table_result_t pending_results [$];
    logic [15:0]   key_file_pool [24];
    logic [15:0]   key_seg_pool [24];
    int            errors;
    int            idle_pct;
    int            stall_pct;
    longint        cycles;

    lrfu_block_replacement dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > 3000000)
            begin
                $display("tb_lrfu_block_replacement failed");
                $finish;
            end
        end
    end

    // decay factor 2^-(f/256) in Q1.16, built from square roots of one half
    function automatic logic [63:0] decay_factor(input logic [7:0] f);
        logic [63:0] acc;
        logic [31:0] half_root [10];
        half_root[0] = 32'd3037000500; half_root[1] = 32'd3611622603;
        half_root[2] = 32'd3938502376; half_root[3] = 32'd4112874773;
        half_root[4] = 32'd4202935002; half_root[5] = 32'd4248701965;
        half_root[6] = 32'd4271771997; half_root[7] = 32'd4283353945;
        half_root[8] = 32'd4289156690; half_root[9] = 32'd4292061010;
        acc = 64'd1 << 32;
        for (int k = 0; k < 8; k++)
        begin
            if (f[k])
                acc = (acc * {32'd0, half_root[7-k]} + (64'd1 << 31)) >> 32;
        end
        return (acc + 64'h8000) >> 16;
    endfunction

    // weight of slot i aged to the current clock
    function automatic logic [31:0] aged_weight(input int i);
        logic [31:0]  dt;
        logic [63:0]  p;
        logic [63:0]  ip;
        logic [127:0] prod;
        dt = mdl_clock - mdl_hit[i];
        p = {32'd0, dt} * {47'd0, mdl_lambda};
        ip = p >> 16;
        if (ip >= 32)
            return 32'd0;
        prod = {96'd0, mdl_weight[i]} * {64'd0, decay_factor(p[15:8])};
        return 32'(prod >> (16 + ip));
    endfunction

    // apply one command to the model and return its result
    function automatic table_result_t table_access(input cmd_t cmd, input logic [15:0] fid,
                                                   input logic [15:0] sid);
        table_result_t r;
        int            hit;
        int            best;
        logic [31:0]   best_w;
        logic [31:0]   w;
        logic [32:0]   sum;
        r = '0;
        hit = -1;
        for (int i = 0; i < mdl_occ; i++)
        begin
            if (hit < 0 && mdl_file[i] == fid && mdl_seg[i] == sid)
                hit = i;
        end
        case (cmd)
            CMD_READ:
            begin
                if (hit >= 0)
                begin
                    sum = {1'b0, aged_weight(hit)} + 33'd65536;
                    mdl_weight[hit] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
                    mdl_hit[hit] = mdl_clock;
                    mdl_clock = mdl_clock + 32'd1;
                    r.found = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (mdl_occ >= ENTRIES)
                begin
                    best = 0;
                    best_w = aged_weight(0);
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        w = aged_weight(i);
                        if (w < best_w)
                        begin
                            best_w = w;
                            best = i;
                        end
                    end
                    r.evicted = 1'b1;
                    r.evict_file = mdl_file[best];
                    r.evict_seg = mdl_seg[best];
                    for (int i = best; i + 1 < ENTRIES; i++)
                    begin
                        mdl_file[i] = mdl_file[i+1];
                        mdl_seg[i] = mdl_seg[i+1];
                        mdl_weight[i] = mdl_weight[i+1];
                        mdl_hit[i] = mdl_hit[i+1];
                    end
                    mdl_occ = ENTRIES - 1;
                    mdl_clock = mdl_clock + 32'd1;
                end
                mdl_file[mdl_occ] = fid;
                mdl_seg[mdl_occ] = sid;
                mdl_weight[mdl_occ] = ONE_Q16;
                mdl_hit[mdl_occ] = mdl_clock;
                mdl_occ = mdl_occ + 1;
            end
            CMD_LOOKUP:
                r.found = (hit >= 0);
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    mdl_weight[i] = 32'd0;
            end
        endcase
        return r;
    endfunction

    // result checker and receiver stalls
    initial
    begin
        table_result_t got;
        table_result_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[33:0];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found)
                        $display("%0t: found expected %h actual %h", $time, want.found,
                                 got.found);
                    if (got.evicted !== want.evicted)
                        $display("%0t: evicted expected %h actual %h", $time, want.evicted,
                                 got.evicted);
                    if (got.evict_file !== want.evict_file)
                        $display("%0t: evict_file_id expected %h actual %h", $time,
                                 want.evict_file, got.evict_file);
                    if (got.evict_seg !== want.evict_seg)
                        $display("%0t: evict_seg_id expected %h actual %h", $time,
                                 want.evict_seg, got.evict_seg);
                    if (got !== want)
                        errors = errors + 1;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // send one item and predict its result on transfer
    task automatic send_item(input cmd_t cmd, input logic [15:0] fid, input logic [15:0] sid);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, sid, fid, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.insert(pending_results.size(), table_access(cmd, fid, sid));
    endtask

    // wait until every expected result has come and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_lambda(input logic [16:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_lambda = value;
    endtask

    // key mostly from a small pool so hits and duplicates occur
    task automatic pick_key(output logic [15:0] fid, output logic [15:0] sid);
        int k;
        if ($urandom_range(0, 99) < 80)
        begin
            k = $urandom_range(0, 23);
            fid = key_file_pool[k];
            sid = key_seg_pool[k];
        end
        else
        begin
            fid = 16'($urandom);
            sid = 16'($urandom);
        end
    endtask

    task automatic random_item();
        logic [15:0] fid;
        logic [15:0] sid;
        int          roll;
        cmd_t        cmd;
        pick_key(fid, sid);
        roll = $urandom_range(0, 99);
        if (roll < 45)
            cmd = CMD_READ;
        else if (roll < 78)
            cmd = CMD_WRITE;
        else if (roll < 96)
            cmd = CMD_LOOKUP;
        else
            cmd = CMD_CLEAR;
        send_item(cmd, fid, sid);
    endtask

    // fill, hit, miss, lookup, clear and evict with extreme keys
    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_item(CMD_READ, 16'h0000, 16'h0000);
        send_item(CMD_WRITE, 16'h0000, 16'h0000);
        send_item(CMD_WRITE, 16'hFFFF, 16'hFFFF);
        send_item(CMD_WRITE, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 13; i++)
            send_item(CMD_WRITE, 16'(16'h5A00 + i), 16'(16'hA500 - i));
        send_item(CMD_READ, 16'hFFFF, 16'hFFFF);
        send_item(CMD_READ, 16'hFFFF, 16'hFFFF);
        send_item(CMD_LOOKUP, 16'h0000, 16'h0000);
        send_item(CMD_LOOKUP, 16'h1234, 16'h4321);
        send_item(CMD_WRITE, 16'hAAAA, 16'h5555);
        send_item(CMD_CLEAR, 16'h0000, 16'h0000);
        send_item(CMD_WRITE, 16'h5555, 16'hAAAA);
        send_item(CMD_READ, 16'h1234, 16'h4321);
    endtask

    // random traffic under one idling profile
    task automatic test_random(input int idle, input int stall, input int count);
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            random_item();
            if (n == count / 2)
                drain();
        end
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        mdl_occ = 0;
        mdl_clock = 32'd0;
        mdl_lambda = LAMBDA_RESET;
        for (int k = 0; k < 24; k++)
        begin
            key_file_pool[k] = (k < 2) ? 16'h0000 : (k < 4) ? 16'hFFFF : 16'($urandom);
            key_seg_pool[k] = (k % 2 == 0) ? 16'($urandom) : ((k < 4) ? 16'hFFFF : 16'h0);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_lambda(17'd0);
        test_random(0, 0, 250);
        write_lambda(17'd65536);
        test_random(81, 0, 300);
        write_lambda(17'h1FFFF);
        test_random(0, 81, 300);
        write_lambda(17'd1);
        test_random(21, 21, 300);
        write_lambda(17'($urandom_range(0, 65536)));
        test_random(0, 0, 300);
        drain();

        if (errors == 0)
            $display("tb_lrfu_block_replacement passed");
        else
            $display("tb_lrfu_block_replacement failed");
        $finish;
    end

endmodule
